// ===== src/modified_utf7_to_utf8_decoder_core_assert.svh =====
// Assertion helpers used by the queue module ut7_fifo.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef MODIFIED_UTF7_TO_UTF8_DECODER_CORE_ASSERT_SVH
`define MODIFIED_UTF7_TO_UTF8_DECODER_CORE_ASSERT_SVH

// Property must hold at every rising clock edge out of reset.
`define UT7_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising clock edge out of reset.
`define UT7_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/ut7_pkg.sv =====
`timescale 1ns / 1ps

package ut7_pkg;

    // Special bytes of the mailbox name syntax
    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    // UTF-16 surrogate prefixes (top six bits of a unit)
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Code point limits for UTF-8 length
    localparam logic [20:0] MAX_1BYTE = 21'h00007F;
    localparam logic [20:0] MAX_2BYTE = 21'h0007FF;
    localparam logic [20:0] MAX_3BYTE = 21'h00FFFF;

    // One queued code point and the index of its final byte
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  last_idx;
    } ut7_entry_t;

    // Write side of the queue
    typedef struct packed {
        logic       valid;
        ut7_entry_t entry;
    } ut7_push_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic       valid;
        ut7_entry_t entry;
    } ut7_head_t;

endpackage

// ===== src/ut7_fifo.sv =====
`timescale 1ns / 1ps
`include "modified_utf7_to_utf8_decoder_core_assert.svh"

module ut7_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ut7_pkg::ut7_push_t push,
    output logic              full,
    output ut7_pkg::ut7_head_t head,
    input  logic              pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ut7_pkg::ut7_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push.valid)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store written entries
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wptr_reg] <= push.entry;
        end
    end

    `UT7_ASSERT_NEVER(a_no_overflow, push.valid && full, "queue written while full")
    `UT7_ASSERT_NEVER(a_no_underflow, pop && !head.valid, "queue read while empty")
    `UT7_ASSERT(a_count_up,
        (push.valid && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)),
        "queue count did not rise on write")

endmodule

// ===== src/ut7_front.sv =====
`timescale 1ns / 1ps

module ut7_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        in_byte,
    input  logic              end_of_string,
    input  logic              full,
    output ut7_pkg::ut7_push_t push
);

    typedef enum logic [1:0] {
        MODE_LIT = 2'd0,
        MODE_AMP = 2'd1,
        MODE_RUN = 2'd2
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [13:0] buf_reg, buf_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [9:0]  hh_reg, hh_next;
    logic        hp_reg, hp_next;

    logic        accept;
    logic        sym_ok;
    logic [5:0]  sym;
    logic        run_active;
    logic        clear;
    logic        lit;
    logic        emit;
    logic [20:0] cp;
    logic        raw;
    logic [13:0] buf_src;
    logic [3:0]  cnt_src;
    logic [9:0]  hh_src;
    logic        hp_src;
    logic [19:0] buf_cat;
    logic [4:0]  cnt_sum;
    logic [2:0]  cnt_left;
    logic [19:0] unit_wide;
    logic [15:0] unit;
    logic [19:0] keep_mask;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Map a base64 symbol (comma alphabet) to its value
    always_comb
    begin
        sym_ok = 1'b1;
        sym    = '0;
        if (in_byte >= 8'h41 && in_byte <= 8'h5A)
        begin
            sym = 6'(in_byte - 8'h41);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h7A)
        begin
            sym = 6'(in_byte - 8'h61 + 8'd26);
        end
        else if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            sym = 6'(in_byte - 8'h30 + 8'd52);
        end
        else if (in_byte == 8'h2B)
        begin
            sym = 6'd62;
        end
        else if (in_byte == 8'h2C)
        begin
            sym = 6'd63;
        end
        else
        begin
            sym_ok = 1'b0;
        end
    end

    // Classify the byte and update decode state
    always_comb
    begin
        mode_next  = mode_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        hh_next    = hh_reg;
        hp_next    = hp_reg;
        emit       = 1'b0;
        raw        = 1'b0;
        cp         = '0;
        run_active = 1'b0;
        clear      = 1'b0;
        lit        = 1'b0;

        case (mode_reg)
            MODE_AMP:
            begin
                if (in_byte == ut7_pkg::CHAR_DASH)
                begin
                    emit      = 1'b1;
                    raw       = 1'b1;
                    cp        = {13'd0, ut7_pkg::CHAR_AMP};
                    mode_next = MODE_LIT;
                end
                else
                begin
                    run_active = 1'b1;
                    clear      = 1'b1;
                end
            end
            MODE_RUN: run_active = 1'b1;
            default:  lit = 1'b1;
        endcase

        buf_src   = clear ? '0 : buf_reg;
        cnt_src   = clear ? '0 : cnt_reg;
        hh_src    = clear ? '0 : hh_reg;
        hp_src    = clear ? 1'b0 : hp_reg;
        buf_cat   = {buf_src, sym};
        cnt_sum   = {1'b0, cnt_src} + 5'd6;
        cnt_left  = 3'(cnt_sum - 5'd16);
        unit_wide = buf_cat >> cnt_left;
        unit      = unit_wide[15:0];
        keep_mask = ~(20'hFFFFF << cnt_left);

        if (run_active)
        begin
            if (sym_ok)
            begin
                mode_next = MODE_RUN;
                hh_next   = hh_src;
                hp_next   = hp_src;
                if (cnt_sum < 5'd16)
                begin
                    buf_next = buf_cat[13:0];
                    cnt_next = cnt_sum[3:0];
                end
                else
                begin
                    buf_next = 14'(buf_cat & keep_mask);
                    cnt_next = {1'b0, cnt_left};
                    if (unit[15:10] == ut7_pkg::HIGH_SURR_TAG)
                    begin
                        hh_next = unit[9:0];
                        hp_next = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (unit[15:10] == ut7_pkg::LOW_SURR_TAG && hp_src)
                        begin
                            cp = ut7_pkg::SUPP_BASE + {1'b0, hh_src, 10'd0}
                                 + {11'd0, unit[9:0]};
                        end
                        else
                        begin
                            cp = {5'd0, unit};
                        end
                        hh_next = '0;
                        hp_next = 1'b0;
                    end
                end
            end
            else
            begin
                // Close the run; a dash is dropped, anything else is literal
                mode_next = MODE_LIT;
                buf_next  = '0;
                cnt_next  = '0;
                hh_next   = '0;
                hp_next   = 1'b0;
                lit       = (in_byte != ut7_pkg::CHAR_DASH);
            end
        end

        if (lit)
        begin
            if (in_byte == ut7_pkg::CHAR_AMP)
            begin
                mode_next = MODE_AMP;
            end
            else
            begin
                emit = 1'b1;
                raw  = 1'b1;
                cp   = {13'd0, in_byte};
            end
        end

        // End of name returns everything to reset
        if (end_of_string)
        begin
            mode_next = MODE_LIT;
            buf_next  = '0;
            cnt_next  = '0;
            hh_next   = '0;
            hp_next   = 1'b0;
        end
    end

    // Queue the code point with its UTF-8 length
    always_comb
    begin
        push.valid     = accept && emit;
        push.entry.cp  = cp;
        if (raw || cp <= ut7_pkg::MAX_1BYTE)
        begin
            push.entry.last_idx = 2'd0;
        end
        else if (cp <= ut7_pkg::MAX_2BYTE)
        begin
            push.entry.last_idx = 2'd1;
        end
        else if (cp <= ut7_pkg::MAX_3BYTE)
        begin
            push.entry.last_idx = 2'd2;
        end
        else
        begin
            push.entry.last_idx = 2'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LIT;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            hh_reg   <= '0;
            hp_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            hh_reg   <= hh_next;
            hp_reg   <= hp_next;
        end
    end

endmodule

// ===== src/ut7_back.sv =====
`timescale 1ns / 1ps

module ut7_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ut7_pkg::ut7_head_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    ut7_pkg::ut7_entry_t entry_reg;
    logic                valid_reg;
    logic [1:0]          idx_reg;
    logic                done_byte;
    logic                load;

    assign m_tvalid  = valid_reg;
    assign m_tlast   = (idx_reg == entry_reg.last_idx);
    assign done_byte = valid_reg && m_tready;
    assign load      = !valid_reg || (done_byte && m_tlast);
    assign pop       = load && head.valid;

    // Pick the UTF-8 byte at the current index
    always_comb
    begin
        m_tdata = entry_reg.cp[7:0];
        case (entry_reg.last_idx)
            2'd1:
            begin
                if (idx_reg == 2'd0) m_tdata = {3'b110, entry_reg.cp[10:6]};
                else                 m_tdata = {2'b10, entry_reg.cp[5:0]};
            end
            2'd2:
            begin
                case (idx_reg)
                    2'd0:    m_tdata = {4'b1110, entry_reg.cp[15:12]};
                    2'd1:    m_tdata = {2'b10, entry_reg.cp[11:6]};
                    default: m_tdata = {2'b10, entry_reg.cp[5:0]};
                endcase
            end
            2'd3:
            begin
                case (idx_reg)
                    2'd0:    m_tdata = {5'b11110, entry_reg.cp[20:18]};
                    2'd1:    m_tdata = {2'b10, entry_reg.cp[17:12]};
                    2'd2:    m_tdata = {2'b10, entry_reg.cp[11:6]};
                    default: m_tdata = {2'b10, entry_reg.cp[5:0]};
                endcase
            end
            default: m_tdata = entry_reg.cp[7:0];
        endcase
    end

    // Load the next code point or advance through its bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= head.valid;
            idx_reg   <= '0;
        end
        else if (done_byte)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= head.entry;
        end
    end

endmodule

// ===== src/modified_utf7_to_utf8_decoder_core.sv =====
// An accepted item is written to the code point queue, then loaded into the output register before its first byte.
// Throughput: one input item per cycle while the code point queue has room;
// the output gives one byte per cycle while m_tready is high, and a multi-byte item holds it until its last byte.
// Queue depth is FIFO_DEPTH code points; a full queue holds off s_tready.
// Reset (rst_n low, asynchronous) returns to literal mode and empties queue and output.
`timescale 1ns / 1ps

module modified_utf7_to_utf8_decoder_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last
);

    ut7_pkg::ut7_push_t push;
    ut7_pkg::ut7_head_t head;
    logic               full;
    logic               pop;

    // Classify bytes and form code points
    ut7_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_byte       (s_tdata),
        .end_of_string (s_tlast),
        .full          (full),
        .push          (push)
    );

    // Hold code points between the two sides
    ut7_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    // Serialize code points into UTF-8 bytes
    ut7_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/utf7_decode_checker.sv =====
`timescale 1ns / 1ps

module utf7_decode_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending
);

    typedef enum logic [1:0] {
        MODE_LITERAL = 2'd0,
        MODE_AMP     = 2'd1,
        MODE_RUN     = 2'd2
    } decode_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_byte_t;

    localparam logic [6:0] SYM_NONE = 7'd64;

    // Predicted decoder state
    decode_mode_t mode      = MODE_LITERAL;
    logic [19:0]  run_bits  = '0;
    logic [4:0]   run_count = '0;
    logic [9:0]   high_bits = '0;
    logic         high_seen = 1'b0;

    utf8_byte_t expected_bytes[$];

    // Map a byte to its base64 value, comma standing in for slash
    function automatic logic [6:0] base64_value(input logic [7:0] b);
        if (b >= "A" && b <= "Z") return 7'(b - 8'h41);
        if (b >= "a" && b <= "z") return 7'(b - 8'h61 + 8'd26);
        if (b >= "0" && b <= "9") return 7'(b - 8'h30 + 8'd52);
        if (b == "+") return 7'd62;
        if (b == ",") return 7'd63;
        return SYM_NONE;
    endfunction

    task automatic clear_run();
        run_bits  = '0;
        run_count = '0;
        high_bits = '0;
        high_seen = 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        expected_bytes.push_back('{data: b, last: 1'b0});
    endtask

    // Encode one code point as UTF-8
    task automatic push_code(input logic [20:0] cp);
        if (cp <= ut7_pkg::MAX_1BYTE)
        begin
            push_byte(cp[7:0]);
        end
        else if (cp <= ut7_pkg::MAX_2BYTE)
        begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
        end
        else if (cp <= ut7_pkg::MAX_3BYTE)
        begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
        else
        begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
    endtask

    // Shift in six bits; decode a UTF-16 unit once sixteen are collected
    task automatic take_symbol(input logic [5:0] sym);
        logic [19:0] shifted;
        logic [15:0] unit;
        logic [20:0] cp;
        run_bits  = {run_bits[13:0], sym};
        run_count = run_count + 5'd6;
        if (run_count >= 5'd16)
        begin
            run_count = run_count - 5'd16;
            shifted   = run_bits >> run_count;
            unit      = shifted[15:0];
            run_bits  = run_bits & ((20'd1 << run_count) - 20'd1);
            if (unit[15:10] == ut7_pkg::HIGH_SURR_TAG)
            begin
                high_bits = unit[9:0];
                high_seen = 1'b1;
            end
            else
            begin
                if (unit[15:10] == ut7_pkg::LOW_SURR_TAG && high_seen)
                    cp = ut7_pkg::SUPP_BASE + {1'b0, high_bits, unit[9:0]};
                else
                    cp = {5'd0, unit};
                high_bits = '0;
                high_seen = 1'b0;
                push_code(cp);
            end
        end
    endtask

    // Predict the bytes caused by one accepted item
    task automatic decode_item(input logic [7:0] b, input logic eos);
        int         start_size;
        logic       done;
        logic [6:0] sym;
        utf8_byte_t tail;
        start_size = expected_bytes.size();
        done       = 1'b0;

        if (mode == MODE_AMP)
        begin
            if (b == ut7_pkg::CHAR_DASH)
            begin
                push_byte(ut7_pkg::CHAR_AMP);
                mode = MODE_LITERAL;
                done = 1'b1;
            end
            else
            begin
                clear_run();
                mode = MODE_RUN;
            end
        end

        if (!done && mode == MODE_RUN)
        begin
            sym = base64_value(b);
            if (sym != SYM_NONE)
            begin
                take_symbol(sym[5:0]);
                done = 1'b1;
            end
            else
            begin
                // close the run; a dash is dropped, anything else falls through
                clear_run();
                mode = MODE_LITERAL;
                if (b == ut7_pkg::CHAR_DASH)
                    done = 1'b1;
            end
        end

        if (!done)
        begin
            if (b == ut7_pkg::CHAR_AMP)
                mode = MODE_AMP;
            else
                push_byte(b);
        end

        // flag the final byte of this item
        if (expected_bytes.size() > start_size)
        begin
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end

        if (eos)
        begin
            clear_run();
            mode = MODE_LITERAL;
        end
    endtask

    // Check output items first, then predict from the input item
    always @(posedge clk or negedge rst_n)
    begin
        utf8_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            clear_run();
            mode       = MODE_LITERAL;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected output item: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_item(s_tdata, s_tlast);
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET  = 280;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SQUEEZE_AT   = 120;
    localparam int SQUEEZE_LEN  = 150;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int         fail_count;
    int         pending;
    int         items_sent  = 0;
    bit         sender_calm = 1'b0;
    logic [7:0] name_bytes[$];
    string      directed_text = "&-&2D3eAA-&3AA.&&-&AOk-";

    modified_utf7_to_utf8_decoder_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf7_decode_checker decode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + {2'b00, v};
        if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
        if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
        if (v == 6'd62) return "+";
        return ",";
    endfunction

    // Offer one item at the falling edge and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eos;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Append a well-formed base64 run built from chosen UTF-16 units
    task automatic add_run();
        logic [15:0] units[$];
        logic [31:0] acc;
        int          acc_bits;
        int          r;
        logic [7:0]  closers[7];
        closers = '{".", " ", "/", ut7_pkg::CHAR_AMP, 8'h00, 8'hFF, "_"};
        name_bytes.push_back(ut7_pkg::CHAR_AMP);
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 5))
                0: units.push_back(16'($urandom_range(0, 16'h7F)));
                1: units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
                2: units.push_back($urandom_range(0, 1)
                                   ? 16'($urandom_range(16'h800, 16'hD7FF))
                                   : 16'($urandom_range(16'hE000, 16'hFFFF)));
                3:
                begin
                    units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
                    units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                4: units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
                default: units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
            endcase
        end
        acc      = '0;
        acc_bits = 0;
        foreach (units[i])
        begin
            acc      = {acc[15:0], units[i]};
            acc_bits += 16;
            while (acc_bits >= 6)
            begin
                acc_bits -= 6;
                name_bytes.push_back(sym_char(6'(acc >> acc_bits)));
            end
        end
        // pad leftover bits with random filler
        if (acc_bits > 0)
            name_bytes.push_back(sym_char(6'((acc << (6 - acc_bits))
                                 | $urandom_range(0, (1 << (6 - acc_bits)) - 1))));
        r = $urandom_range(0, 9);
        if (r < 7)
            name_bytes.push_back(ut7_pkg::CHAR_DASH);
        else if (r < 9)
            name_bytes.push_back(closers[$urandom_range(0, 6)]);
    endtask

    // Build one mailbox name from random segments
    task automatic build_name();
        name_bytes.delete();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        if ($urandom_range(0, 3) == 0)
                            name_bytes.push_back(8'($urandom_range(0, 255)));
                        else
                            name_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    end
                end
                3:
                begin
                    name_bytes.push_back(ut7_pkg::CHAR_AMP);
                    name_bytes.push_back(ut7_pkg::CHAR_DASH);
                end
                9:
                begin
                    // broken run with random symbols
                    name_bytes.push_back(ut7_pkg::CHAR_AMP);
                    repeat ($urandom_range(0, 7))
                        name_bytes.push_back(sym_char(6'($urandom_range(0, 63))));
                    if ($urandom_range(0, 1) == 1)
                        name_bytes.push_back(ut7_pkg::CHAR_DASH);
                end
                default: add_run();
            endcase
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // extremes, escapes, surrogate pair, lone low half, run closers
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        for (int i = 0; i < directed_text.len(); i++)
            send_item(directed_text[i], 1'b0);
        send_item(ut7_pkg::CHAR_AMP, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 4) == 0);
            build_name();
            foreach (name_bytes[i])
                send_item(name_bytes[i], i == name_bytes.size() - 1);
        end
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("** modified_utf7_to_utf8_decoder_core: PASSED **");
        else
            $display("** modified_utf7_to_utf8_decoder_core: FAILED **");
        $finish;
    end

    // Receiver: random stalls, calm stretches, one long hold-off
    initial
    begin
        int  stall_left;
        int  calm_left;
        bit  squeezed;
        stall_left = 0;
        calm_left  = 0;
        squeezed   = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!squeezed && items_sent >= SQUEEZE_AT)
            begin
                squeezed   = 1'b1;
                stall_left = SQUEEZE_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready = 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                m_tready = 1'b1;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                calm_left = $urandom_range(30, 80);
                m_tready  = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                m_tready   = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** modified_utf7_to_utf8_decoder_core: FAILED **");
        $finish;
    end

endmodule

// ===== modified_utf7_to_utf8_decoder_core.f =====
+incdir+src
src/ut7_pkg.sv
src/ut7_fifo.sv
src/ut7_front.sv
src/ut7_back.sv
src/modified_utf7_to_utf8_decoder_core.sv
sim/utf7_decode_checker.sv
sim/testbench.sv
